// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the probe monitor.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- hdl/plm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_pkg
// Shared constants and types of the probe loss and RTT monitor.
// ----------------------------------------------------------------------------
package plm_pkg;

    // Configuration port geometry.
    localparam int PADDR_W = 4;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_RUN_LOSS_LIMIT    = 2'd0,
        REG_WINDOW_MINUTES    = 2'd1,
        REG_WINDOW_LOSS_LIMIT = 2'd2
    } reg_idx_t;

    // Window close codes carried in window_event.
    typedef enum logic [1:0] {
        WEV_NONE      = 2'd0,
        WEV_RECORD    = 2'd1,
        WEV_NO_RECORD = 2'd2
    } wevent_t;

    // Arithmetic constants.
    localparam logic [6:0]  PCT_FULL        = 7'd100;
    localparam logic [25:0] USEC_PER_MINUTE = 26'd60000000;
    localparam int          SPAN_W          = 33;

    // Serial divider: the dividend is wide enough for lost_count * 100.
    localparam int DIV_W     = 39;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration as seen by the core, with the window length in usec.
    typedef struct packed {
        logic [15:0]       run_loss_limit;
        logic [6:0]        window_minutes;
        logic [6:0]        window_loss_limit;
        logic [SPAN_W-1:0] window_span;
    } cfg_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/plm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_in_if
// Probe channel: one word per test probe, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plm_in_if;

    logic        valid;
    logic        ready;
    logic        send_ok;
    logic        reply_seen;
    logic        stamp_valid;
    logic [31:0] rtt_usec;
    logic [31:0] now_usec;

    modport source (
        output valid, send_ok, reply_seen, stamp_valid, rtt_usec, now_usec,
        input  ready
    );

    modport sink (
        input  valid, send_ok, reply_seen, stamp_valid, rtt_usec, now_usec,
        output ready
    );

endinterface
`default_nettype wire

// ----- hdl/plm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_out_if
// Result channel: one status word per probe, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plm_out_if;

    logic        valid;
    logic        ready;
    logic        source_valid;
    logic [31:0] probes_sent;
    logic [31:0] probes_lost;
    logic [6:0]  loss_pct;
    logic [31:0] loss_run;
    logic [31:0] rtt_min;
    logic [31:0] rtt_max;
    logic [31:0] rtt_avg;
    logic        run_alarm;
    logic        window_alarm;
    logic [1:0]  window_event;

    modport source (
        output valid, source_valid, probes_sent, probes_lost, loss_pct, loss_run,
               rtt_min, rtt_max, rtt_avg, run_alarm, window_alarm, window_event,
        input  ready
    );

    modport sink (
        input  valid, source_valid, probes_sent, probes_lost, loss_pct, loss_run,
               rtt_min, rtt_max, rtt_avg, run_alarm, window_alarm, window_event,
        output ready
    );

endinterface
`default_nettype wire

// ----- hdl/plm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_regs
// APB register file: run limit, window length and window loss limit.
// The window length in microseconds is worked out once, on the write.
// ----------------------------------------------------------------------------
module plm_regs import plm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_RUN_LOSS_LIMIT:
                begin
                    cfg_next.run_loss_limit = pwdata[15:0];
                end
                REG_WINDOW_MINUTES:
                begin
                    cfg_next.window_minutes = pwdata[6:0];
                    cfg_next.window_span    = SPAN_W'(pwdata[6:0])
                                              * SPAN_W'(USEC_PER_MINUTE);
                end
                REG_WINDOW_LOSS_LIMIT:
                begin
                    cfg_next.window_loss_limit = pwdata[6:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (idx)
            REG_RUN_LOSS_LIMIT:    prdata = {16'd0, cfg_reg.run_loss_limit};
            REG_WINDOW_MINUTES:    prdata = {25'd0, cfg_reg.window_minutes};
            REG_WINDOW_LOSS_LIMIT: prdata = {25'd0, cfg_reg.window_loss_limit};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/plm_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plm_divider import plm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     dq_reg;
    logic [DIV_W-1:0]     dq_next;
    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [31:0]          dsr_reg;
    logic [31:0]          dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [32:0]          shifted;
    logic [33:0]          diff;
    logic                 fits;

    // One trial subtraction: remainder with the next dividend bit shifted in.
    assign shifted = {rem_reg, dq_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = !diff[33];

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dq_next   = req.dividend;
            rem_next  = 32'd0;
            dsr_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Dividend bits leave at the top, quotient bits enter at the bottom.
            dq_next  = {dq_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[31:0] : shifted[31:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg   <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/probe_loss_rtt_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// probe_loss_rtt_monitor
// Loss and round-trip monitor for a stream of test probes. Counts sent and
// lost probes, tracks the loss run, keeps RTT min/max/average and closes the
// loss averaging window with a percent, an alarm and a record flag.
//
//   Channel   Kind        Direction   Word
//   probe     valid/ready in          one probe report
//   result    valid/ready out         one status word per probe
//   apb       APB         in/out      three configuration registers
//
// A failed send goes straight to the emit step. A sent probe passes the
// average and percent steps, the close step when the window closes, and the
// emit step; the serial divider runs once for the average when the RTT total
// and the received count are nonzero, once for the loss percent on a close.
// Reset is asynchronous, active low, and clears all statistics at once.
// The result sits in an output register; a stalled result holds the block
// only when the next word is ready to be written.
// ----------------------------------------------------------------------------
module probe_loss_rtt_monitor import plm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    plm_in_if.sink             probe,
    plm_out_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_MEAN_WAIT,
        S_PCT,
        S_PCT_WAIT,
        S_CLOSE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [31:0] sent;
        logic [31:0] lost;
        logic [31:0] total;
        logic [31:0] lowest;
        logic [31:0] highest;
        logic [31:0] mean;
        logic [6:0]  pct;
        logic [31:0] run;
        logic        flagged;
        logic [31:0] wstart;
        logic        started;
    } stats_t;

    typedef struct packed {
        logic        source_valid;
        logic [31:0] probes_sent;
        logic [31:0] probes_lost;
        logic [6:0]  loss_pct;
        logic [31:0] loss_run;
        logic [31:0] rtt_min;
        logic [31:0] rtt_max;
        logic [31:0] rtt_avg;
        logic        run_alarm;
        logic        window_alarm;
        wevent_t     window_event;
    } result_t;

    cfg_t        cfg;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    state_t      state_reg;
    state_t      state_next;
    stats_t      st_reg;
    stats_t      st_next;
    logic        send_ok_reg;
    logic        send_ok_next;
    logic        reply_reg;
    logic        reply_next;
    logic [31:0] now_reg;
    logic [31:0] now_next;
    logic        expired_reg;
    logic        expired_next;
    logic        ralarm_reg;
    logic        ralarm_next;
    logic        walarm_reg;
    logic        walarm_next;
    wevent_t     wevent_reg;
    wevent_t     wevent_next;
    logic [31:0] snap_min_reg;
    logic [31:0] snap_min_next;
    logic [31:0] snap_max_reg;
    logic [31:0] snap_max_next;
    logic [31:0] snap_avg_reg;
    logic [31:0] snap_avg_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     out_next;

    logic             accept;
    logic [31:0]      ws_eff;
    logic [31:0]      elapsed;
    logic [31:0]      run_inc;
    logic [31:0]      recvd;
    logic [DIV_W-1:0] lost_x100;
    logic [6:0]       pct_q;

    plm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshake.
    assign probe.ready = (state_reg == S_IDLE);
    assign accept      = probe.valid && probe.ready;

    // Window age; the first probe opens the window at its own time.
    assign ws_eff  = st_reg.started ? st_reg.wstart : probe.now_usec;
    assign elapsed = probe.now_usec - ws_eff;

    assign run_inc   = st_reg.run + 32'd1;
    assign recvd     = st_reg.sent - st_reg.lost;
    assign lost_x100 = DIV_W'(st_reg.lost) * DIV_W'(PCT_FULL);

    // Loss percent limited to full loss.
    assign pct_q = (div_rsp.quotient > DIV_W'(PCT_FULL)) ? PCT_FULL
                                                        : div_rsp.quotient[6:0];

    // Result port.
    assign result.valid        = out_valid_reg;
    assign result.source_valid = out_reg.source_valid;
    assign result.probes_sent  = out_reg.probes_sent;
    assign result.probes_lost  = out_reg.probes_lost;
    assign result.loss_pct     = out_reg.loss_pct;
    assign result.loss_run     = out_reg.loss_run;
    assign result.rtt_min      = out_reg.rtt_min;
    assign result.rtt_max      = out_reg.rtt_max;
    assign result.rtt_avg      = out_reg.rtt_avg;
    assign result.run_alarm    = out_reg.run_alarm;
    assign result.window_alarm = out_reg.window_alarm;
    assign result.window_event = out_reg.window_event;

    // Sequencer: update, average, loss percent, window close, emit.
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        send_ok_next   = send_ok_reg;
        reply_next     = reply_reg;
        now_next       = now_reg;
        expired_next   = expired_reg;
        ralarm_next    = ralarm_reg;
        walarm_next    = walarm_reg;
        wevent_next    = wevent_reg;
        snap_min_next  = snap_min_reg;
        snap_max_next  = snap_max_reg;
        snap_avg_next  = snap_avg_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_req        = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    send_ok_next = probe.send_ok;
                    reply_next   = probe.reply_seen;
                    now_next     = probe.now_usec;
                    ralarm_next  = 1'b0;
                    walarm_next  = 1'b0;
                    wevent_next  = WEV_NONE;
                    expired_next = probe.send_ok
                                   && ({1'b0, elapsed} >= cfg.window_span);
                    if (!st_reg.started)
                    begin
                        st_next.wstart  = probe.now_usec;
                        st_next.started = 1'b1;
                    end
                    if (probe.send_ok)
                    begin
                        st_next.sent = st_reg.sent + 32'd1;
                        if (!probe.reply_seen)
                        begin
                            // Lost probe extends the run; alarm once per run.
                            st_next.lost = st_reg.lost + 32'd1;
                            st_next.run  = run_inc;
                            if ((run_inc > {16'd0, cfg.run_loss_limit}) && !st_reg.flagged)
                            begin
                                ralarm_next     = 1'b1;
                                st_next.flagged = 1'b1;
                            end
                        end
                        else
                        begin
                            // A stored zero min or max counts as empty.
                            if (probe.stamp_valid)
                            begin
                                if ((st_reg.lowest == 32'd0) || (probe.rtt_usec < st_reg.lowest))
                                begin
                                    st_next.lowest = probe.rtt_usec;
                                end
                                if ((st_reg.highest == 32'd0) || (probe.rtt_usec > st_reg.highest))
                                begin
                                    st_next.highest = probe.rtt_usec;
                                end
                                st_next.total = st_reg.total + probe.rtt_usec;
                            end
                            st_next.run     = 32'd0;
                            st_next.flagged = 1'b0;
                        end
                        state_next = S_MEAN;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_MEAN:
            begin
                // Average over received probes; kept when nothing to divide.
                if ((st_reg.total != 32'd0) && (recvd != 32'd0))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(st_reg.total);
                    div_req.divisor  = recvd;
                    state_next       = S_MEAN_WAIT;
                end
                else
                begin
                    state_next = S_PCT;
                end
            end

            S_MEAN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    st_next.mean = div_rsp.quotient[31:0];
                    state_next   = S_PCT;
                end
            end

            S_PCT:
            begin
                if (expired_reg)
                begin
                    if (st_reg.sent != 32'd0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = lost_x100;
                        div_req.divisor  = st_reg.sent;
                        state_next       = S_PCT_WAIT;
                    end
                    else
                    begin
                        st_next.pct = 7'd0;
                        state_next  = S_CLOSE;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_PCT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    st_next.pct = pct_q;
                    state_next  = S_CLOSE;
                end
            end

            S_CLOSE:
            begin
                // Report the closed window, then start a fresh one.
                walarm_next = (st_reg.pct > cfg.window_loss_limit);
                if (!reply_reg && (st_reg.pct == PCT_FULL))
                begin
                    wevent_next = WEV_NO_RECORD;
                end
                else
                begin
                    wevent_next = WEV_RECORD;
                end
                snap_min_next   = st_reg.lowest;
                snap_max_next   = st_reg.highest;
                snap_avg_next   = st_reg.mean;
                st_next.total   = 32'd0;
                st_next.lost    = 32'd0;
                st_next.sent    = 32'd0;
                st_next.lowest  = 32'd0;
                st_next.highest = 32'd0;
                st_next.mean    = 32'd0;
                st_next.wstart  = now_reg;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.source_valid = send_ok_reg;
                    out_next.probes_sent  = st_reg.sent;
                    out_next.probes_lost  = st_reg.lost;
                    out_next.loss_pct     = st_reg.pct;
                    out_next.loss_run     = st_reg.run;
                    out_next.run_alarm    = ralarm_reg;
                    out_next.window_alarm = walarm_reg;
                    out_next.window_event = wevent_reg;
                    if (wevent_reg != WEV_NONE)
                    begin
                        out_next.rtt_min = snap_min_reg;
                        out_next.rtt_max = snap_max_reg;
                        out_next.rtt_avg = snap_avg_reg;
                    end
                    else
                    begin
                        out_next.rtt_min = st_reg.lowest;
                        out_next.rtt_max = st_reg.highest;
                        out_next.rtt_avg = st_reg.mean;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= '0;
            send_ok_reg   <= 1'b0;
            reply_reg     <= 1'b0;
            now_reg       <= '0;
            expired_reg   <= 1'b0;
            ralarm_reg    <= 1'b0;
            walarm_reg    <= 1'b0;
            wevent_reg    <= WEV_NONE;
            snap_min_reg  <= '0;
            snap_max_reg  <= '0;
            snap_avg_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            send_ok_reg   <= send_ok_next;
            reply_reg     <= reply_next;
            now_reg       <= now_next;
            expired_reg   <= expired_next;
            ralarm_reg    <= ralarm_next;
            walarm_reg    <= walarm_next;
            wevent_reg    <= wevent_next;
            snap_min_reg  <= snap_min_next;
            snap_max_reg  <= snap_max_next;
            snap_avg_reg  <= snap_avg_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/plm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks on the result words of the probe monitor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plm_checker import plm_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        source_valid,
    input logic [31:0] probes_sent,
    input logic [31:0] probes_lost,
    input logic [6:0]  loss_pct,
    input logic [31:0] loss_run,
    input logic        run_alarm,
    input logic        window_alarm,
    input logic [1:0]  window_event
);

    logic closed;
    logic quiet;
    logic cleared;
    logic stalled;

    // Shorthands for the properties below.
    assign closed  = (window_event != WEV_NONE);
    assign quiet   = !run_alarm && !window_alarm && !closed;
    assign cleared = (probes_sent == 32'd0) && (probes_lost == 32'd0)
                     && (loss_pct <= PCT_FULL);
    assign stalled = res_valid && !res_ready;

    // A failed send reports no alarm and no window close.
    `PLM_ASSERT_IMPL(a_fail_quiet, clk, rst_n, res_valid && !source_valid, quiet)

    // A run alarm means at least one loss is in the current run.
    `PLM_ASSERT_IMPL(a_run_alarm_run, clk, rst_n, res_valid && run_alarm, loss_run != 32'd0)

    // A window alarm only comes with a window close.
    `PLM_ASSERT_IMPL(a_walarm_close, clk, rst_n, res_valid && window_alarm, closed)

    // A closed window leaves the counters cleared.
    `PLM_ASSERT_IMPL(a_close_clears, clk, rst_n, res_valid && closed, cleared)

    // A stalled result word holds.
    `PLM_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, res_valid && $stable({probes_sent, loss_run}))

endmodule

bind probe_loss_rtt_monitor plm_checker u_plm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .source_valid (result.source_valid),
    .probes_sent  (result.probes_sent),
    .probes_lost  (result.probes_lost),
    .loss_pct     (result.loss_pct),
    .loss_run     (result.loss_run),
    .run_alarm    (result.run_alarm),
    .window_alarm (result.window_alarm),
    .window_event (result.window_event)
);
`default_nettype wire

// ----- tb/sv/tb_probe_loss_rtt_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_probe_loss_rtt_monitor
// Self-checking bench for the probe loss and RTT monitor. A driver feeds probe
// words from a queue and an in-bench model of the loss, run and RTT statistics
// predicts one status word per probe. A monitor compares every status word,
// field by field, while both channels idle and stall at random. The
// configuration registers are rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_probe_loss_rtt_monitor;
    import plm_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic        send_ok;
        logic        reply_seen;
        logic        stamp_valid;
        logic [31:0] rtt_usec;
        logic [31:0] now_usec;
    } probe_word_t;

    typedef struct packed {
        logic        source_valid;
        logic [31:0] probes_sent;
        logic [31:0] probes_lost;
        logic [6:0]  loss_pct;
        logic [31:0] loss_run;
        logic [31:0] rtt_min;
        logic [31:0] rtt_max;
        logic [31:0] rtt_avg;
        logic        run_alarm;
        logic        window_alarm;
        wevent_t     window_event;
    } status_word_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    plm_in_if  probe_if ();
    plm_out_if result_if ();

    probe_loss_rtt_monitor u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .probe   (probe_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Probe words waiting to be sent and status words still owed by the block.
    probe_word_t  pending_probes[$];
    status_word_t expected_status[$];
    int           errors;

    // Monitor statistics as the block should hold them.
    logic [31:0] win_sent;
    logic [31:0] win_lost;
    logic [31:0] rtt_sum;
    logic [31:0] rtt_lo;
    logic [31:0] rtt_hi;
    logic [31:0] rtt_mean;
    logic [6:0]  closed_pct;
    logic [31:0] run_len;
    logic        run_alarmed;
    logic [31:0] win_start;
    logic        win_started;

    // Register copies.
    logic [15:0] cfg_run_limit;
    logic [6:0]  cfg_win_minutes;
    logic [6:0]  cfg_pct_limit;

    // Stimulus and flow control.
    logic [31:0] sim_now;
    bit          sender_calm;
    bit          receiver_calm;
    bit          hold_request;
    int          send_gap;
    int          recv_stall;
    int          hold_left;
    int          idle_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Work out the status word for one accepted probe and queue it.
    function automatic void predict_status(probe_word_t p);
        status_word_t s;
        logic [31:0]  received;
        logic [31:0]  elapsed;
        logic [63:0]  span;
        logic [63:0]  pct;
        s = '0;
        s.window_event = WEV_NONE;
        if (!win_started)
        begin
            win_start   = p.now_usec;
            win_started = 1'b1;
        end
        if (p.send_ok)
        begin
            s.source_valid = 1'b1;
            win_sent++;
            if (!p.reply_seen)
            begin
                win_lost++;
                run_len++;
                if (run_len > {16'd0, cfg_run_limit} && !run_alarmed)
                begin
                    s.run_alarm = 1'b1;
                    run_alarmed = 1'b1;
                end
            end
            else
            begin
                // A zero stored extreme means empty; a zero rtt keeps it empty.
                if (p.stamp_valid)
                begin
                    if (rtt_lo == 0 || p.rtt_usec < rtt_lo)
                        rtt_lo = p.rtt_usec;
                    if (rtt_hi == 0 || p.rtt_usec > rtt_hi)
                        rtt_hi = p.rtt_usec;
                    rtt_sum += p.rtt_usec;
                end
                run_len     = '0;
                run_alarmed = 1'b0;
            end
            received = win_sent - win_lost;
            if (rtt_sum != 0 && received != 0)
                rtt_mean = rtt_sum / received;
        end
        s.rtt_min = rtt_lo;
        s.rtt_max = rtt_hi;
        s.rtt_avg = rtt_mean;

        // Window close: the span is full width, so long windows never close.
        elapsed = p.now_usec - win_start;
        span    = 64'(cfg_win_minutes) * 64'(USEC_PER_MINUTE);
        if (p.send_ok && {32'd0, elapsed} >= span)
        begin
            win_start = p.now_usec;
            if (win_sent == 0)
                pct = '0;
            else
                pct = ({32'd0, win_lost} * 64'd100) / {32'd0, win_sent};
            if (pct > 64'(PCT_FULL))
                pct = 64'(PCT_FULL);
            closed_pct = pct[6:0];
            if (closed_pct > cfg_pct_limit)
                s.window_alarm = 1'b1;
            if (!p.reply_seen && closed_pct == PCT_FULL)
                s.window_event = WEV_NO_RECORD;
            else
                s.window_event = WEV_RECORD;
            rtt_sum  = '0;
            win_lost = '0;
            win_sent = '0;
            rtt_lo   = '0;
            rtt_hi   = '0;
            rtt_mean = '0;
        end
        s.probes_sent = win_sent;
        s.probes_lost = win_lost;
        s.loss_pct    = closed_pct;
        s.loss_run    = run_len;
        expected_status.push_back(s);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare the status word on the result channel with the oldest prediction.
    function automatic void check_status();
        status_word_t want;
        if (expected_status.size() == 0)
        begin
            $display("%0t: status word arrived with none expected", $time);
            errors++;
            return;
        end
        want = expected_status.pop_front();
        check_field("source_valid", want.source_valid, result_if.source_valid);
        check_field("probes_sent", want.probes_sent, result_if.probes_sent);
        check_field("probes_lost", want.probes_lost, result_if.probes_lost);
        check_field("loss_pct", want.loss_pct, result_if.loss_pct);
        check_field("loss_run", want.loss_run, result_if.loss_run);
        check_field("rtt_min", want.rtt_min, result_if.rtt_min);
        check_field("rtt_max", want.rtt_max, result_if.rtt_max);
        check_field("rtt_avg", want.rtt_avg, result_if.rtt_avg);
        check_field("run_alarm", want.run_alarm, result_if.run_alarm);
        check_field("window_alarm", want.window_alarm, result_if.window_alarm);
        check_field("window_event", want.window_event, result_if.window_event);
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_rtt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 13)
            return '1;
        else if (r < 30)
            return $urandom;
        else
            return $urandom_range(1, 200000);
    endfunction

    // Move the probe clock on so that windows close every few probes.
    function automatic logic [31:0] advance_now();
        logic [63:0] span;
        span = 64'(cfg_win_minutes) * 64'(USEC_PER_MINUTE);
        if ($urandom_range(0, 99) < 3)
            sim_now = $urandom;
        else if (span == 0 || span > 64'hFFFF_FFFF)
            sim_now = $urandom_range(0, 1) ? 32'($urandom) : sim_now + $urandom_range(0, 1000);
        else
            sim_now += $urandom_range(0, 32'(span / 6));
        return sim_now;
    endfunction

    function automatic void add_probe(logic s, logic r, logic st, logic [31:0] rtt,
                                      logic [31:0] now);
        probe_word_t p;
        p.send_ok     = s;
        p.reply_seen  = r;
        p.stamp_valid = st;
        p.rtt_usec    = rtt;
        p.now_usec    = now;
        pending_probes.push_back(p);
    endfunction

    // Mostly bursts of losses and replies, with failed sends and noise mixed in.
    function automatic void add_random_probes(int count);
        int n;
        int kind;
        int len;
        int run_cap;
        n = 0;
        while (n < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                add_probe(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, advance_now());
                n++;
            end
            else if (kind < 20)
            begin
                add_probe(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom, advance_now());
                n++;
            end
            else if (kind < 55)
            begin
                run_cap = (cfg_run_limit < 16) ? int'(cfg_run_limit) : 5;
                len     = $urandom_range(1, run_cap + 3);
                repeat (len)
                begin
                    add_probe(1'b1, 1'b0, 1'($urandom_range(0, 1)), $urandom, advance_now());
                    n++;
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    add_probe(1'b1, 1'b1, 1'($urandom_range(0, 6) != 0), pick_rtt(),
                              advance_now());
                    n++;
                end
            end
        end
    endfunction

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RUN_LOSS_LIMIT:    cfg_run_limit   = value[15:0];
            REG_WINDOW_MINUTES:    cfg_win_minutes = value[6:0];
            REG_WINDOW_LOSS_LIMIT: cfg_pct_limit   = value[6:0];
            default: ;
        endcase
    endtask

    task automatic configure(int run_limit, int win_minutes, int pct_limit);
        write_reg(REG_RUN_LOSS_LIMIT, run_limit);
        write_reg(REG_WINDOW_MINUTES, win_minutes);
        write_reg(REG_WINDOW_LOSS_LIMIT, pct_limit);
    endtask

    task automatic wait_drained();
        while (pending_probes.size() != 0 || expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int run_limit, int win_minutes, int pct_limit, int count,
                             bit s_calm, bit r_calm, bit hold);
        configure(run_limit, win_minutes, pct_limit);
        sender_calm   = s_calm;
        receiver_calm = r_calm;
        add_random_probes(count);
        if (hold)
            hold_request = 1'b1;
        wait_drained();
    endtask

    // Probe driver: holds a word until it is taken, then waits out a gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            probe_if.valid <= 1'b0;
        end
        else
        begin
            if (probe_if.valid && probe_if.ready)
                predict_status(pending_probes.pop_front());
            if (!(probe_if.valid && !probe_if.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    probe_if.valid <= 1'b0;
                end
                else if (pending_probes.size() != 0)
                begin
                    {probe_if.send_ok, probe_if.reply_seen, probe_if.stamp_valid,
                     probe_if.rtt_usec, probe_if.now_usec} <= pending_probes[0];
                    probe_if.valid <= 1'b1;
                    send_gap = sender_calm ? 0 : pick_gap();
                end
                else
                begin
                    probe_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each word taken and paces ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
                check_status();
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
                if (!receiver_calm && $urandom_range(0, 7) == 0)
                    recv_stall = pick_gap();
            end
        end
    end

    // Watchdog: too long without any word or register access means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((probe_if.valid && probe_if.ready) || (result_if.valid && result_if.ready) ||
                psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL probe_loss_rtt_monitor");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] t0;
        errors        = 0;
        win_sent      = '0;
        win_lost      = '0;
        rtt_sum       = '0;
        rtt_lo        = '0;
        rtt_hi        = '0;
        rtt_mean      = '0;
        closed_pct    = '0;
        run_len       = '0;
        run_alarmed   = 1'b0;
        win_start     = '0;
        win_started   = 1'b0;
        cfg_run_limit   = '0;
        cfg_win_minutes = '0;
        cfg_pct_limit   = '0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        hold_request  = 1'b0;
        send_gap      = 0;
        recv_stall    = 0;
        hold_left     = 0;
        idle_cycles   = 0;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        probe_if.valid       = 1'b0;
        probe_if.send_ok     = 1'b0;
        probe_if.reply_seen  = 1'b0;
        probe_if.stamp_valid = 1'b0;
        probe_if.rtt_usec    = '0;
        probe_if.now_usec    = '0;
        result_if.ready      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed probes on a one minute window, starting just below the time wrap.
        configure(2, 1, 40);
        t0 = 32'hFFFF_F000;
        // A failed send still starts the window.
        add_probe(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, t0);
        // Zero rtt leaves min and max empty; then the largest and smallest rtt.
        add_probe(1'b1, 1'b1, 1'b1, 32'd0, t0 + 10);
        add_probe(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, t0 + 20);
        // The total wraps to zero here, so the average stays as it was.
        add_probe(1'b1, 1'b1, 1'b1, 32'd1, t0 + 30);
        // Reply without a valid stamp: rtt is ignored.
        add_probe(1'b1, 1'b1, 1'b0, 32'd5, t0 + 40);
        // Loss run beyond the limit fires the run alarm once.
        add_probe(1'b1, 1'b0, 1'b1, 32'h1234_5678, t0 + 50);
        add_probe(1'b1, 1'b0, 1'b0, 32'hEDCB_A987, t0 + 60);
        add_probe(1'b1, 1'b0, 1'b1, 32'h0000_0000, t0 + 70);
        add_probe(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, t0 + 80);
        add_probe(1'b0, 1'b0, 1'b0, 32'd0, t0 + 90);
        add_probe(1'b1, 1'b0, 1'b1, 32'd9, t0 + 100);
        // Reply exactly at the window length: window closes with a record.
        add_probe(1'b1, 1'b1, 1'b1, 32'd100, t0 + 60000000);
        // All losses in the next window: closes without a record.
        add_probe(1'b1, 1'b0, 1'b1, 32'd3, t0 + 60000001);
        add_probe(1'b1, 1'b0, 1'b1, 32'd3, t0 + 120000001);
        add_probe(1'b1, 1'b1, 1'b1, 32'd7, 32'h0000_0000);
        add_probe(1'b1, 1'b1, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
        add_probe(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        // Random phases: extremes first, then random settings.
        sim_now = '0;
        run_phase(0, 1, 0, 280, 1'b0, 1'b0, 1'b0);
        run_phase(65535, 127, 127, 150, 1'b0, 1'b1, 1'b0);
        run_phase(5, 71, 100, 200, 1'b1, 1'b0, 1'b1);
        run_phase(3, 0, 50, 150, 1'b1, 1'b1, 1'b0);
        repeat (3)
            run_phase($urandom_range(0, 8), $urandom_range(0, 3), $urandom_range(0, 100), 150,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS probe_loss_rtt_monitor");
        else
            $display("FAIL probe_loss_rtt_monitor");
        $finish;
    end

endmodule
